### hdl/hfp_pkg.sv
// ----------------------------------------------------------------------------
// hfp_pkg
// shared types and constants for the header frame parser with ring fifos
// ----------------------------------------------------------------------------
package hfp_pkg;

   localparam int BYTE_W = 8;
   localparam int CMD_W = 3;
   localparam int CSR_IDX_W = 4;

   localparam int FRAME_FIFO_DEPTH_DEF = 8;
   localparam int FORWARD_FIFO_DEPTH_DEF = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECEIVE     = 3'd0,
      CMD_FORWARD     = 3'd1,
      CMD_POP_FRAME   = 3'd2,
      CMD_POP_FORWARD = 3'd3,
      CMD_FLUSH       = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_BYTE   = 4'd0,
      CSR_STATUS_CODE_A = 4'd1,
      CSR_STATUS_CODE_B = 4'd2,
      CSR_STATUS_CODE_C = 4'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic exec;   // execute the presented request this cycle
   } dp_cmd_type;

endpackage

### hdl/hfp_ctrl.sv
// ----------------------------------------------------------------------------
// hfp_ctrl
// request/response sequencer: one request in flight, result held until taken
// ----------------------------------------------------------------------------
module hfp_ctrl
   import hfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type dp_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign dp_cmd.exec = (state_ff == ST_IDLE) && req_valid;

endmodule

### hdl/hfp_datapath.sv
// ----------------------------------------------------------------------------
// hfp_datapath
// config registers, parser, forward and frame ring fifos, result registers
// ----------------------------------------------------------------------------
module hfp_datapath
   import hfp_pkg::*;
#(
   parameter int FRAME_FIFO_DEPTH   = FRAME_FIFO_DEPTH_DEF,
   parameter int FORWARD_FIFO_DEPTH = FORWARD_FIFO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_write_data,
   output logic                 rsp_frame_valid,
   output logic [BYTE_W-1:0]    rsp_frame_code,
   output logic                 rsp_forward_valid,
   output logic [BYTE_W-1:0]    rsp_forward_byte,
   output logic                 rsp_forward_dropped,
   output logic                 rsp_frame_dropped
);

   localparam int FRM_PW = $clog2(FRAME_FIFO_DEPTH);
   localparam int FWD_PW = $clog2(FORWARD_FIFO_DEPTH);
   localparam logic [FRM_PW-1:0] FRM_LAST = FRM_PW'(FRAME_FIFO_DEPTH - 1);
   localparam logic [FWD_PW-1:0] FWD_LAST = FWD_PW'(FORWARD_FIFO_DEPTH - 1);

   // configuration
   logic [BYTE_W-1:0] header_ff, code_a_ff, code_b_ff, code_c_ff;

   // parser and pointers
   logic              header_seen_ff, header_seen_in;
   logic [FRM_PW-1:0] frm_wp_ff, frm_wp_in, frm_rp_ff, frm_rp_in;
   logic [FWD_PW-1:0] fwd_wp_ff, fwd_wp_in, fwd_rp_ff, fwd_rp_in;

   // storage
   logic [BYTE_W-1:0] frame_mem [FRAME_FIFO_DEPTH];
   logic [BYTE_W-1:0] forward_mem [FORWARD_FIFO_DEPTH];
   logic [BYTE_W-1:0] frm_rd_ff, fwd_rd_ff;

   // result flags
   logic frm_valid_ff, frm_valid_in;
   logic fwd_valid_ff, fwd_valid_in;
   logic fwd_drop_ff, fwd_drop_in;
   logic frm_drop_ff, frm_drop_in;

   logic              frm_push, fwd_push, frm_pop, fwd_pop;
   logic [FRM_PW-1:0] frm_wp_next, frm_rp_next;
   logic [FWD_PW-1:0] fwd_wp_next, fwd_rp_next;
   logic              frm_full, fwd_full, frm_empty, fwd_empty;
   logic              is_header, code_hit;
   cmd_type           cmd;

   assign cmd = cmd_type'(req_command);

   assign frm_wp_next = (frm_wp_ff == FRM_LAST) ? '0 : frm_wp_ff + 1'b1;
   assign frm_rp_next = (frm_rp_ff == FRM_LAST) ? '0 : frm_rp_ff + 1'b1;
   assign fwd_wp_next = (fwd_wp_ff == FWD_LAST) ? '0 : fwd_wp_ff + 1'b1;
   assign fwd_rp_next = (fwd_rp_ff == FWD_LAST) ? '0 : fwd_rp_ff + 1'b1;

   assign frm_full  = (frm_wp_next == frm_rp_ff);
   assign fwd_full  = (fwd_wp_next == fwd_rp_ff);
   assign frm_empty = (frm_wp_ff == frm_rp_ff);
   assign fwd_empty = (fwd_wp_ff == fwd_rp_ff);

   assign is_header = (req_rx_byte == header_ff);
   assign code_hit  = (req_rx_byte == code_a_ff) || (req_rx_byte == code_b_ff)
                      || (req_rx_byte == code_c_ff);

   always_comb begin
      header_seen_in = header_seen_ff;
      frm_wp_in      = frm_wp_ff;
      frm_rp_in      = frm_rp_ff;
      fwd_wp_in      = fwd_wp_ff;
      fwd_rp_in      = fwd_rp_ff;
      frm_valid_in   = 1'b0;
      fwd_valid_in   = 1'b0;
      fwd_drop_in    = 1'b0;
      frm_drop_in    = 1'b0;
      frm_push       = 1'b0;
      fwd_push       = 1'b0;
      frm_pop        = 1'b0;
      fwd_pop        = 1'b0;
      unique case (cmd)
         CMD_RECEIVE, CMD_FORWARD: begin
            fwd_drop_in = fwd_full;
            fwd_push    = !fwd_full;
            if (cmd == CMD_RECEIVE) begin
               // header compare wins over the status codes
               if (is_header) begin
                  header_seen_in = 1'b1;
               end else if (header_seen_ff) begin
                  header_seen_in = 1'b0;
                  if (code_hit) begin
                     frm_drop_in = frm_full;
                     frm_push    = !frm_full;
                  end
               end
            end
         end
         CMD_POP_FRAME: begin
            frm_valid_in = !frm_empty;
            frm_pop      = !frm_empty;
         end
         CMD_POP_FORWARD: begin
            fwd_valid_in = !fwd_empty;
            fwd_pop      = !fwd_empty;
         end
         CMD_FLUSH: begin
            frm_wp_in      = '0;
            frm_rp_in      = '0;
            header_seen_in = 1'b0;
         end
         default: ;
      endcase
      if (frm_push) frm_wp_in = frm_wp_next;
      if (fwd_push) fwd_wp_in = fwd_wp_next;
      if (frm_pop)  frm_rp_in = frm_rp_next;
      if (fwd_pop)  fwd_rp_in = fwd_rp_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff      <= '0;
         code_a_ff      <= '0;
         code_b_ff      <= '0;
         code_c_ff      <= '0;
         header_seen_ff <= 1'b0;
         frm_wp_ff      <= '0;
         frm_rp_ff      <= '0;
         fwd_wp_ff      <= '0;
         fwd_rp_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_HEADER_BYTE:   header_ff <= csr_write_data;
               CSR_STATUS_CODE_A: code_a_ff <= csr_write_data;
               CSR_STATUS_CODE_B: code_b_ff <= csr_write_data;
               CSR_STATUS_CODE_C: code_c_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (dp_cmd.exec) begin
            header_seen_ff <= header_seen_in;
            frm_wp_ff      <= frm_wp_in;
            frm_rp_ff      <= frm_rp_in;
            fwd_wp_ff      <= fwd_wp_in;
            fwd_rp_ff      <= fwd_rp_in;
         end
      end
   end

   // result registers, loaded once per request and held until taken
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         frm_valid_ff <= frm_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         fwd_drop_ff  <= fwd_drop_in;
         frm_drop_ff  <= frm_drop_in;
      end
   end

   // frame ring storage
   always_ff @(posedge clock) begin
      if (dp_cmd.exec && frm_push) begin
         frame_mem[frm_wp_ff] <= req_rx_byte;
      end
      if (dp_cmd.exec && frm_pop) begin
         frm_rd_ff <= frame_mem[frm_rp_ff];
      end
   end

   // forward ring storage
   always_ff @(posedge clock) begin
      if (dp_cmd.exec && fwd_push) begin
         forward_mem[fwd_wp_ff] <= req_rx_byte;
      end
      if (dp_cmd.exec && fwd_pop) begin
         fwd_rd_ff <= forward_mem[fwd_rp_ff];
      end
   end

   assign rsp_frame_valid     = frm_valid_ff;
   assign rsp_frame_code      = frm_valid_ff ? frm_rd_ff : '0;
   assign rsp_forward_valid   = fwd_valid_ff;
   assign rsp_forward_byte    = fwd_valid_ff ? fwd_rd_ff : '0;
   assign rsp_forward_dropped = fwd_drop_ff;
   assign rsp_frame_dropped   = frm_drop_ff;

endmodule

### hdl/header_frame_parser_with_fifos_unit.sv
// ----------------------------------------------------------------------------
// header_frame_parser_with_fifos_unit
// link byte parser with a forward ring fifo and a frame code ring fifo
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   req       req_valid / req_stall  req_command, req_rx_byte
//   rsp       rsp_valid / rsp_stall  frame/forward valid, code, byte, drops
//   csr       csr_write_enable       csr_index, csr_write_data (no read-back)
//
// each request is executed at the transfer edge (pointer update, fifo write or
// registered fifo read), and the next cycle shows the result
// one request is in flight at a time; req_stall stays high while a result waits
// rsp_stall holds the result and the request side stays stalled with it
// synchronous active-high reset clears pointers, parser and config registers;
// fifo storage is not cleared and needs no clearing pass
//
module header_frame_parser_with_fifos_unit
   import hfp_pkg::*;
#(
   parameter int FRAME_FIFO_DEPTH   = FRAME_FIFO_DEPTH_DEF,
   parameter int FORWARD_FIFO_DEPTH = FORWARD_FIFO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_frame_valid,
   output logic [BYTE_W-1:0]    rsp_frame_code,
   output logic                 rsp_forward_valid,
   output logic [BYTE_W-1:0]    rsp_forward_byte,
   output logic                 rsp_forward_dropped,
   output logic                 rsp_frame_dropped,
   // register write port
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_write_data
);

   dp_cmd_type dp_cmd;

   // sequencer: accepts a request, then holds the result until it is taken
   hfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // parser, both rings and the result registers
   hfp_datapath #(
      .FRAME_FIFO_DEPTH   (FRAME_FIFO_DEPTH),
      .FORWARD_FIFO_DEPTH (FORWARD_FIFO_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .req_command         (req_command),
      .req_rx_byte         (req_rx_byte),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_frame_valid     (rsp_frame_valid),
      .rsp_frame_code      (rsp_frame_code),
      .rsp_forward_valid   (rsp_forward_valid),
      .rsp_forward_byte    (rsp_forward_byte),
      .rsp_forward_dropped (rsp_forward_dropped),
      .rsp_frame_dropped   (rsp_frame_dropped)
   );

endmodule

### hdl/hfp_checker.sv
// ----------------------------------------------------------------------------
// hfp_checker
// port-level checks on the header frame parser, bound to the top level
// ----------------------------------------------------------------------------
module hfp_checker
   import hfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_frame_valid,
   input logic [BYTE_W-1:0]    rsp_frame_code,
   input logic                 rsp_forward_valid,
   input logic                 rsp_forward_dropped,
   input logic                 rsp_frame_dropped
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // every request transfer yields a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after request transfer");

   // no new request while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with result pending");

   // a result reports at most one kind of event
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_frame_valid, rsp_forward_valid,
                              rsp_forward_dropped || rsp_frame_dropped}))
      else $error("conflicting result flags");

   // code field is zero when no frame popped
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |-> rsp_frame_code == '0)
      else $error("frame code set without frame");

endmodule

bind header_frame_parser_with_fifos_unit hfp_checker u_hfp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_frame_valid     (rsp_frame_valid),
   .rsp_frame_code      (rsp_frame_code),
   .rsp_forward_valid   (rsp_forward_valid),
   .rsp_forward_dropped (rsp_forward_dropped),
   .rsp_frame_dropped   (rsp_frame_dropped)
);
